/* sv/cpss_pkg.sv */
// Shared types, register codes and segment tables for the charlieplexed segment scanner.
package cpss_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int PAIR_W      = 6;
    localparam int PIN_W       = 3;
    localparam int GLYPH_W     = 7;
    localparam int NUM_CAND    = 18;
    localparam int CAND_W      = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_LETTER_MODE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SHOWN_VALUE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TENS_CHAR     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UNITS_CHAR    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SHOW_PERCENT  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SHOW_BATTERY  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERT_ENABLE = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERT_INTERVAL = 3'd7;

    localparam logic [6:0] SHOWN_MAX     = 7'd100;
    localparam logic [7:0] CHAR_SPACE    = 8'd32;
    localparam logic [7:0] CASE_OFFSET   = 8'd32;
    localparam logic [14:0] DIV10_MUL    = 15'd205;
    localparam int DIV10_SHIFT           = 11;
    localparam logic [PIN_W-1:0] MAX_PIN = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FILL
    } t_state;

    function automatic logic [GLYPH_W-1:0] numeral_glyph(input logic [3:0] d);
        logic [GLYPH_W-1:0] g;
        case (d)
            4'd0:    g = 7'h3F;
            4'd1:    g = 7'h06;
            4'd2:    g = 7'h5B;
            4'd3:    g = 7'h4F;
            4'd4:    g = 7'h66;
            4'd5:    g = 7'h6D;
            4'd6:    g = 7'h7D;
            4'd7:    g = 7'h07;
            4'd8:    g = 7'h7F;
            4'd9:    g = 7'h6F;
            default: g = 7'h00;
        endcase
        return g;
    endfunction

    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [7:0] ch);
        logic [7:0] up;
        logic [GLYPH_W-1:0] g;
        up = ch;
        if (ch >= "a" && ch <= "z") begin
            up = ch - CASE_OFFSET;
        end
        if (up >= "0" && up <= "9") begin
            g = numeral_glyph(4'(up - "0"));
        end else begin
            case (up)
                "A":     g = 7'h77;
                "B":     g = 7'h7C;
                "C":     g = 7'h39;
                "D":     g = 7'h5E;
                "E":     g = 7'h79;
                "F":     g = 7'h71;
                "G":     g = 7'h7D;
                "H":     g = 7'h76;
                "I":     g = 7'h06;
                "J":     g = 7'h04;
                "L":     g = 7'h38;
                "N":     g = 7'h55;
                "O":     g = 7'h3F;
                "P":     g = 7'h73;
                "Q":     g = 7'h77;
                "R":     g = 7'h50;
                "S":     g = 7'h6D;
                "T":     g = 7'h78;
                "U":     g = 7'h3E;
                "Y":     g = 7'h6E;
                "-":     g = 7'h40;
                "_":     g = 7'h08;
                default: g = 7'h00;
            endcase
        end
        return g;
    endfunction

    // Pin pair of each candidate slot, written in octal as {first pin, second pin}.
    function automatic logic [PAIR_W-1:0] cand_pair(input logic [CAND_W-1:0] c);
        logic [PAIR_W-1:0] p;
        case (c)
            5'd0:    p = 6'o32;
            5'd1:    p = 6'o31;
            5'd2:    p = 6'o21;
            5'd3:    p = 6'o12;
            5'd4:    p = 6'o23;
            5'd5:    p = 6'o13;
            5'd6:    p = 6'o14;
            5'd7:    p = 6'o24;
            5'd8:    p = 6'o34;
            5'd9:    p = 6'o10;
            5'd10:   p = 6'o01;
            5'd11:   p = 6'o20;
            5'd12:   p = 6'o02;
            5'd13:   p = 6'o30;
            5'd14:   p = 6'o03;
            5'd15:   p = 6'o04;
            5'd16:   p = 6'o42;
            5'd17:   p = 6'o40;
            default: p = 6'o00;
        endcase
        return p;
    endfunction

endpackage

/* sv/charlieplex_segment_scanner_core.sv */
// Top level of the charlieplexed segment scanner: configuration, segment list and tick path.
// Each accepted tick is registered, then the pin pair of the next lit segment is registered
// as the result. One tick is taken per clock cycle unless a rebuild or stalled result
// holds the input, limited only by the list read and the 32-bit elapsed-time compare. A
// configuration write starts a list rebuild (one load state, then one fill step per candidate
// segment) that stalls the input. With an empty list a tick is consumed without a result.
module charlieplex_segment_scanner_core #(
    parameter int MAX_SEGMENTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [31:0]                   i_now_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [cpss_pkg::PIN_W-1:0]    o_high_pin,
    output logic [cpss_pkg::PIN_W-1:0]    o_low_pin,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cpss_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [cpss_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cpss_pkg::*;

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    logic                   r_letter_mode;
    logic [6:0]             r_shown_value;
    logic [7:0]             r_tens_char;
    logic [7:0]             r_units_char;
    logic                   r_show_percent;
    logic                   r_show_battery;
    logic                   r_invert_enable;
    logic [15:0]            r_invert_interval;

    t_state                 r_state;
    t_state                 n_state;
    logic                   s_busy;
    logic                   s_load;
    logic                   s_fill;

    logic [NUM_CAND-1:0]    r_mask;
    logic [CAND_W-1:0]      r_cand;
    logic [PAIR_W-1:0]      r_list [MAX_SEGMENTS];
    logic [CNT_W-1:0]       r_count;
    logic [IDX_W-1:0]       r_scan;
    logic                   r_polarity;
    logic [31:0]            r_last_toggle;

    logic                   r_in_valid;
    logic [31:0]            r_now;
    logic                   r_out_valid;
    logic [PIN_W-1:0]       r_high_pin;
    logic [PIN_W-1:0]       r_low_pin;

    logic                   cfg_write;
    logic [6:0]             cfg_value_sat;
    logic [14:0]            div_prod;
    logic [3:0]             tens_digit;
    logic [3:0]             units_digit;
    logic                   hundred;
    logic [GLYPH_W-1:0]     tens_glyph;
    logic [GLYPH_W-1:0]     units_glyph;
    logic [NUM_CAND-1:0]    mask_calc;

    logic                   in_take;
    logic                   advance;
    logic                   has_seg;
    logic [31:0]            elapsed;
    logic                   toggle;
    logic                   n_polarity;
    logic [IDX_W-1:0]       n_scan;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid & o_cfg_ready;
    assign cfg_value_sat = (i_cfg_data[6:0] > SHOWN_MAX) ? SHOWN_MAX : i_cfg_data[6:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_letter_mode     <= 1'b0;
            r_shown_value     <= 7'd0;
            r_tens_char       <= CHAR_SPACE;
            r_units_char      <= CHAR_SPACE;
            r_show_percent    <= 1'b0;
            r_show_battery    <= 1'b0;
            r_invert_enable   <= 1'b0;
            r_invert_interval <= 16'd0;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                REG_LETTER_MODE:     r_letter_mode     <= i_cfg_data[0];
                REG_SHOWN_VALUE:     r_shown_value     <= cfg_value_sat;
                REG_TENS_CHAR:       r_tens_char       <= i_cfg_data[7:0];
                REG_UNITS_CHAR:      r_units_char      <= i_cfg_data[7:0];
                REG_SHOW_PERCENT:    r_show_percent    <= i_cfg_data[0];
                REG_SHOW_BATTERY:    r_show_battery    <= i_cfg_data[0];
                REG_INVERT_ENABLE:   r_invert_enable   <= i_cfg_data[0];
                REG_INVERT_INTERVAL: r_invert_interval <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        if (cfg_write) begin
            n_state = ST_LOAD;
        end else begin
            unique case (r_state)
                ST_IDLE: n_state = ST_IDLE;
                ST_LOAD: n_state = ST_FILL;
                ST_FILL: n_state = (r_cand == CAND_W'(NUM_CAND - 1)) ? ST_IDLE : ST_FILL;
                default: n_state = ST_IDLE;
            endcase
        end
    end

    always_comb begin
        s_busy = 1'b1;
        s_load = 1'b0;
        s_fill = 1'b0;
        unique case (r_state)
            ST_IDLE: s_busy = 1'b0;
            ST_LOAD: s_load = 1'b1;
            ST_FILL: s_fill = 1'b1;
            default: s_busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Decimal digits of the shown value by reciprocal multiplication, exact for 0..100.
    always_comb begin
        div_prod    = 15'(r_shown_value) * DIV10_MUL;
        tens_digit  = 4'(div_prod >> DIV10_SHIFT);
        units_digit = 4'(r_shown_value - 7'(tens_digit) * 7'd10);
        if (r_letter_mode) begin
            hundred     = (r_tens_char == "1") && (r_units_char == "0");
            tens_glyph  = glyph_of(r_tens_char);
            units_glyph = glyph_of(r_units_char);
        end else begin
            hundred     = (r_shown_value == SHOWN_MAX);
            tens_glyph  = numeral_glyph(tens_digit);
            units_glyph = numeral_glyph(units_digit);
        end
        if (hundred) begin
            tens_glyph  = numeral_glyph(4'd0);
            units_glyph = numeral_glyph(4'd0);
        end
        mask_calc = {r_show_battery, r_show_percent, units_glyph, tens_glyph,
                     hundred, hundred};
    end

    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_mask <= mask_calc;
            r_cand <= '0;
        end else if (s_fill) begin
            r_cand <= r_cand + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fill && r_mask[r_cand] && (r_count < CNT_W'(MAX_SEGMENTS))) begin
            r_list[r_count[IDX_W-1:0]] <= cand_pair(r_cand);
        end
    end

    assign advance    = r_in_valid & ~s_busy & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = s_busy | (r_in_valid & ~advance);
    assign in_take    = i_in_valid & ~o_in_stall;

    assign has_seg    = (r_count != '0);
    assign elapsed    = r_now - r_last_toggle;
    assign toggle     = r_invert_enable & (elapsed > {16'd0, r_invert_interval});
    assign n_polarity = r_polarity ^ toggle;
    assign n_scan     = ((CNT_W'(r_scan) + 1'b1) == r_count) ? '0 : r_scan + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_scan        <= '0;
            r_polarity    <= 1'b0;
            r_last_toggle <= 32'd0;
        end else if (s_load) begin
            r_count <= '0;
            r_scan  <= '0;
        end else if (s_fill) begin
            if (r_mask[r_cand] && (r_count < CNT_W'(MAX_SEGMENTS))) begin
                r_count <= r_count + 1'b1;
            end
        end else if (advance && has_seg) begin
            r_scan     <= n_scan;
            r_polarity <= n_polarity;
            if (toggle) begin
                r_last_toggle <= r_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance && has_seg) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_now <= i_now_ms;
        end
        if (advance && has_seg) begin
            r_high_pin <= n_polarity ? r_list[r_scan][PIN_W-1:0]
                                     : r_list[r_scan][PAIR_W-1:PIN_W];
            r_low_pin  <= n_polarity ? r_list[r_scan][PAIR_W-1:PIN_W]
                                     : r_list[r_scan][PIN_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_high_pin  = r_high_pin;
    assign o_low_pin   = r_low_pin;

endmodule

/* sv/cpss_checker.sv */
// Port-level checker for the charlieplexed segment scanner and its bind statement.
module cpss_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [cpss_pkg::PIN_W-1:0]        o_high_pin,
    input logic [cpss_pkg::PIN_W-1:0]        o_low_pin,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready
);
    import cpss_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result request dropped while stalled");

    // A stalled result keeps its pins.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_high_pin) && $stable(o_low_pin))
        else $error("result pins changed while stalled");

    // Every segment joins two different pins of the five.
    a_pins_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_high_pin != o_low_pin))
        else $error("high and low pin are the same");

    a_pins_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_high_pin <= MAX_PIN) && (o_low_pin <= MAX_PIN))
        else $error("pin index out of range");

    // A configuration write starts a list rebuild, which holds off input.
    a_cfg_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> o_in_stall)
        else $error("input accepted during list rebuild");

endmodule

bind charlieplex_segment_scanner_core cpss_checker u_cpss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_high_pin  (o_high_pin),
    .o_low_pin   (o_low_pin),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);
